### hw/rtl/drs_pkg.sv
// Package for the disk request scheduler: sizes, policy codes, sequencer states.
// No dependencies.
package drs_pkg;
    localparam int QUEUE_DEPTH = 16;
    localparam int TRACK_BITS  = 16;
    localparam int TAG_BITS    = 16;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] POL_FIFO  = 3'd0;
    localparam logic [2:0] POL_SSTF  = 3'd1;
    localparam logic [2:0] POL_LOOK  = 3'd2;
    localparam logic [2:0] POL_CLOOK = 3'd3;
    localparam logic [2:0] POL_FLOOK = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_SCAN2, ST_FETCH, ST_SHIFT, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SM_DIR, SM_NEAR, SM_MIN
    } scan_mode_t;
endpackage

### hw/rtl/disk_request_scheduler.sv
// Disk request scheduler top level: queue registers, scan sequencer, result register.
// Depends on drs_pkg.
//
//  channel | ports                                        | direction
//  s_      | s_valid s_ready s_action s_track s_request_tag | in
//  m_      | m_valid m_ready m_picked_* m_seek_distance ... | out
//  cfg_    | cfg_valid cfg_ready cfg_policy               | in
//
// Enqueue and empty pick: the result valid is registered from ST_DONE. Pick (SSTF, LOOK, C-LOOK,
// F-LOOK): one scan pass of one entry per cycle through one shared distance/compare unit, a
// second pass when the directed scan finds nothing, a fetch state, then one shift of the queue
// per cycle to close the gap. FIFO picks the oldest entry: no scan, straight to the fetch state.
// aresetn is synchronous, active low; it empties the queue, head 0, sweep up.
// s_ready is low from acceptance until the result transfer completes.
module disk_request_scheduler
    import drs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [TRACK_BITS-1:0] s_track,
    input  logic [TAG_BITS-1:0]   s_request_tag,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_picked_valid,
    output logic [TAG_BITS-1:0]   m_picked_tag,
    output logic [TRACK_BITS-1:0] m_picked_track,
    output logic [TRACK_BITS-1:0] m_seek_distance,
    output logic                  m_sweep_up,
    output logic                  m_dropped,
    output logic [CNT_BITS-1:0]   m_pending_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_policy
);
    logic [TRACK_BITS-1:0] trk_reg [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]   tag_reg [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] act_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [TRACK_BITS-1:0] head_reg;
    logic                  up_reg;
    logic [2:0]            pol_reg;
    state_t                state_reg, state_next;
    scan_mode_t            mode_reg;
    logic                  dir_reg;
    logic                  only_act_reg;
    logic [IDX_BITS-1:0]   i_reg;
    logic [IDX_BITS-1:0]   best_reg;
    logic                  found_reg;
    logic [TRACK_BITS-1:0] bestd_reg;
    logic [TRACK_BITS-1:0] sel_trk_reg;

    logic                  last;
    logic [TRACK_BITS-1:0] t_cur, gap;
    logic                  qual, better;
    logic [CNT_BITS-1:0]   cnt_m1;

    assign cfg_ready = (state_reg == ST_IDLE) && !m_valid;
    assign s_ready   = (state_reg == ST_IDLE) && !m_valid;
    assign cnt_m1    = cnt_reg - 1'b1;
    assign last      = ({1'b0, i_reg} == cnt_m1);
    assign t_cur     = trk_reg[i_reg];
    assign gap       = (t_cur >= head_reg) ? t_cur - head_reg : head_reg - t_cur;

    // shared compare unit
    always_comb begin
        qual   = 1'b1;
        better = 1'b0;
        case (mode_reg)
            SM_DIR: begin
                if (only_act_reg && !act_reg[i_reg]) qual = 1'b0;
                if (dir_reg ? (t_cur < head_reg) : (t_cur > head_reg)) qual = 1'b0;
                better = qual && (!found_reg || gap < bestd_reg);
            end
            SM_NEAR: better = !found_reg || gap < bestd_reg;
            SM_MIN:  better = !found_reg || t_cur < sel_trk_reg;
            default: better = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (!s_action || cnt_reg == '0)
                        state_next = ST_DONE;
                    else if (pol_reg inside {POL_SSTF, POL_LOOK, POL_CLOOK, POL_FLOOK})
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FETCH;
                end
            end
            ST_SCAN:  if (last) state_next = ST_SCAN2;
            ST_SCAN2: state_next = (!found_reg && mode_reg == SM_DIR) ? ST_SCAN : ST_FETCH;
            ST_FETCH: state_next = ST_SHIFT;
            ST_SHIFT: if (last || cnt_reg <= CNT_BITS'(1)) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            act_reg   <= '0;
            cnt_reg   <= '0;
            head_reg  <= '0;
            up_reg    <= 1'b1;
            pol_reg   <= POL_FIFO;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) pol_reg <= cfg_policy;
            if (m_valid && m_ready) m_valid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        m_picked_valid  <= 1'b0;
                        m_picked_tag    <= '0;
                        m_picked_track  <= '0;
                        m_seek_distance <= '0;
                        m_dropped       <= 1'b0;
                        i_reg           <= '0;
                        found_reg       <= 1'b0;
                        bestd_reg       <= '0;
                        best_reg        <= '0;
                        dir_reg         <= (pol_reg == POL_CLOOK) ? 1'b1 : up_reg;
                        only_act_reg    <= (pol_reg == POL_FLOOK);
                        mode_reg        <= (pol_reg == POL_SSTF) ? SM_NEAR : SM_DIR;
                        if (!s_action) begin
                            if (cnt_reg >= CNT_BITS'(QUEUE_DEPTH)) begin
                                m_dropped <= 1'b1;
                            end else begin
                                trk_reg[cnt_reg[IDX_BITS-1:0]] <= s_track;
                                tag_reg[cnt_reg[IDX_BITS-1:0]] <= s_request_tag;
                                act_reg[cnt_reg[IDX_BITS-1:0]] <= 1'b0;
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                        end else if (cnt_reg != '0) begin
                            if (pol_reg == POL_FLOOK && act_reg == '0) begin
                                for (int k = 0; k < QUEUE_DEPTH; k++)
                                    act_reg[k] <= (CNT_BITS'(k) < cnt_reg);
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (better) begin
                        found_reg   <= 1'b1;
                        best_reg    <= i_reg;
                        bestd_reg   <= gap;
                        sel_trk_reg <= t_cur;
                    end
                    if (!last) begin
                        i_reg <= i_reg + 1'b1;
                    end else begin
                        i_reg <= '0;
                    end
                end
                ST_SCAN2: begin
                    // second pass when the directed scan found nothing
                    if (!found_reg && mode_reg == SM_DIR) begin
                        if (pol_reg == POL_CLOOK) begin
                            mode_reg <= SM_MIN;
                        end else begin
                            dir_reg <= !dir_reg;
                            up_reg  <= !dir_reg;
                        end
                    end else begin
                        i_reg <= best_reg;
                    end
                end
                ST_FETCH: begin
                    m_picked_valid  <= 1'b1;
                    m_picked_tag    <= tag_reg[i_reg];
                    m_picked_track  <= t_cur;
                    m_seek_distance <= gap;
                    head_reg        <= t_cur;
                end
                ST_SHIFT: begin
                    if (!last && cnt_reg > CNT_BITS'(1)) begin
                        trk_reg[i_reg] <= trk_reg[i_reg + 1'b1];
                        tag_reg[i_reg] <= tag_reg[i_reg + 1'b1];
                        act_reg[i_reg] <= act_reg[i_reg + 1'b1];
                        i_reg <= i_reg + 1'b1;
                    end else begin
                        act_reg[cnt_m1[IDX_BITS-1:0]] <= 1'b0;
                        cnt_reg <= cnt_m1;
                    end
                end
                ST_DONE: m_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_sweep_up      = up_reg;
    assign m_pending_count = cnt_reg;
endmodule
